>>> rtl/rlhc_pkg.sv
// ----------------------------------------------------------------------------
// rlhc_pkg
// Shared types and constants of the rate limited heading controller: the
// configuration register set, controller commands and datapath status.
// ----------------------------------------------------------------------------
package rlhc_pkg;

   // Configuration register indexes
   localparam logic [1:0] CSR_MAX_TURN_RATE = 2'd0;
   localparam logic [1:0] CSR_MIN_TURN_RATE = 2'd1;
   localparam logic [1:0] CSR_ERROR_GAIN    = 2'd2;
   localparam logic [1:0] CSR_SLEW_SPEED    = 2'd3;

   localparam int unsigned CSR_INDEX_BITS = 2;
   localparam int unsigned CSR_DATA_BITS  = 20;

   // Reset values of the configuration registers
   localparam logic [19:0] MAX_TURN_RATE_RST = 20'd131072;
   localparam logic [19:0] MIN_TURN_RATE_RST = 20'd0;
   localparam logic [15:0] ERROR_GAIN_RST    = 16'd2560;
   localparam logic [15:0] SLEW_SPEED_RST    = 16'd2560;

   // Turn rate saturation and unity blend fraction (Q8.24)
   localparam logic [20:0] RATE_LIMIT = 21'd1048575;
   localparam logic [31:0] ALPHA_ONE  = 32'd16777216;

   typedef struct packed {
      logic [19:0] max_turn_rate;
      logic [19:0] min_turn_rate;
      logic [15:0] error_gain;
      logic [15:0] slew_speed;
   } rlhc_cfg_type;

   // Datapath operations issued by the controller
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_ERR,
      OP_GAIN,
      OP_DIFF,
      OP_BLEND,
      OP_RATE,
      OP_TRAVEL,
      OP_DIV,
      OP_OUT_HOLD,
      OP_OUT_TOL,
      OP_OUT_SNAP,
      OP_OUT_MOVE
   } rlhc_op_type;

   typedef struct packed {
      rlhc_op_type op;
   } rlhc_cmd_type;

   typedef struct packed {
      logic dt_zero;
      logic in_tol;
      logic snap;
      logic div_busy;
   } rlhc_status_type;

endpackage

>>> rtl/rlhc_csr.sv
// ----------------------------------------------------------------------------
// rlhc_csr
// Configuration register file: four write-only registers loaded from the
// plain write port.
// ----------------------------------------------------------------------------
module rlhc_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [rlhc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [rlhc_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   output rlhc_pkg::rlhc_cfg_type               cfg
);
   import rlhc_pkg::*;

   rlhc_cfg_type cfg_ff;
   rlhc_cfg_type cfg_in;

   // Decode the register index
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_MAX_TURN_RATE: cfg_in.max_turn_rate = csr_wdata;
            CSR_MIN_TURN_RATE: cfg_in.min_turn_rate = csr_wdata;
            CSR_ERROR_GAIN:    cfg_in.error_gain    = csr_wdata[15:0];
            CSR_SLEW_SPEED:    cfg_in.slew_speed    = csr_wdata[15:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_turn_rate <= MAX_TURN_RATE_RST;
         cfg_ff.min_turn_rate <= MIN_TURN_RATE_RST;
         cfg_ff.error_gain    <= ERROR_GAIN_RST;
         cfg_ff.slew_speed    <= SLEW_SPEED_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/rlhc_divider.sv
// ----------------------------------------------------------------------------
// rlhc_divider
// Restoring radix-2 divider: one quotient bit per cycle, a 16-bit divisor
// and a DIVIDEND_BITS wide dividend.
// ----------------------------------------------------------------------------
module rlhc_divider #(
   parameter int unsigned DIVIDEND_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [DIVIDEND_BITS-1:0] dividend,
   input  logic [15:0]              divisor,
   output logic                     busy,
   output logic [DIVIDEND_BITS-1:0] quotient
);
   localparam int unsigned CNT_BITS = $clog2(DIVIDEND_BITS + 1);

   logic [CNT_BITS-1:0]      cnt_ff;
   logic [CNT_BITS-1:0]      cnt_in;
   logic [15:0]              rem_ff;
   logic [15:0]              rem_in;
   logic [DIVIDEND_BITS-1:0] quo_ff;
   logic [DIVIDEND_BITS-1:0] quo_in;
   logic [15:0]              div_ff;
   logic [15:0]              div_in;
   logic [16:0]              trial;
   logic                     fits;

   // Shift in the next dividend bit and try to subtract the divisor
   always_comb begin
      trial  = {rem_ff, quo_ff[DIVIDEND_BITS-1]};
      fits   = trial >= {1'b0, div_ff};
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      div_in = div_ff;
      if (start) begin
         cnt_in = CNT_BITS'(DIVIDEND_BITS);
         rem_in = '0;
         quo_in = dividend;
         div_in = divisor;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         rem_in = fits ? 16'(trial - {1'b0, div_ff}) : trial[15:0];
         quo_in = {quo_ff[DIVIDEND_BITS-2:0], fits};
      end
   end

   // Hold the iteration count under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign busy     = cnt_ff != '0;
   assign quotient = quo_ff;

endmodule

>>> rtl/rlhc_datapath.sv
// ----------------------------------------------------------------------------
// rlhc_datapath
// Heading controller arithmetic: wrapped error, gain and clamp, rate blend,
// travel check, snap rate division and the result register.
// ----------------------------------------------------------------------------
module rlhc_datapath #(
   parameter int unsigned ANGLE_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  rlhc_pkg::rlhc_cfg_type    cfg,
   input  rlhc_pkg::rlhc_cmd_type    cmd,
   output rlhc_pkg::rlhc_status_type status,
   input  logic [15:0]               req_current_heading,
   input  logic [15:0]               req_target_heading,
   input  logic [15:0]               req_tick_time,
   output logic [15:0]               rsp_new_heading,
   output logic signed [20:0]        rsp_turn_rate,
   output logic                      rsp_arrived
);
   import rlhc_pkg::*;

   localparam int unsigned A  = ANGLE_BITS;
   localparam int unsigned IW = (A > 16) ? A : 16;
   localparam int unsigned DW = A + 16;
   localparam int unsigned WW = (A + 8 > 20) ? A + 8 : 20;
   localparam int unsigned CW = (A + 16 > 36) ? A + 16 : 36;
   localparam int unsigned HW = (A > 21) ? A : 21;

   // Operand and intermediate registers
   logic [A-1:0]  cur_ff;
   logic [A-1:0]  tgt_ff;
   logic [15:0]   dt_ff;
   logic [A-1:0]  mag_e_ff;
   logic          err_neg_ff;
   logic [DW-1:0] gprod_ff;
   logic [31:0]   alpha_ff;
   logic [20:0]   desired_ff;
   logic [20:0]   mag_diff_ff;
   logic          diff_neg_ff;
   logic [24:0]   alpha_cap_ff;
   logic [21:0]   step_ff;
   logic [20:0]   rate_new_ff;
   logic [35:0]   mag_d_ff;
   logic [20:0]   rate_ff;
   logic [20:0]   rate_in;
   logic [15:0]   heading_ff;
   logic [20:0]   turn_ff;
   logic          arrived_ff;

   logic [IW-1:0] cur_ext;
   logic [IW-1:0] tgt_ext;
   logic [A-1:0]  wrap_diff;
   logic          wrap_neg;
   logic [A-1:0]  half_turn;
   logic [WW-1:0] want_w;
   logic [19:0]   min_eff;
   logic [19:0]   want_c;
   logic [20:0]   want_s;
   logic [20:0]   desired_w;
   logic [21:0]   diff_w;
   logic [45:0]   blend_prod;
   logic [45:0]   blend_rnd;
   logic [22:0]   rate_sum;
   logic [20:0]   rate_sat;
   logic [20:0]   rate_abs;
   logic [36:0]   adv_rnd;
   logic [20:0]   adv;
   logic [HW-1:0] head_sum;
   logic [DW-1:0] quo;
   logic [20:0]   q_sat;
   logic [20:0]   q_signed;
   logic [A-1:0]  head_sel;
   logic [IW-1:0] head_ext;

   // Input headings at the angle width
   assign cur_ext = IW'(req_current_heading);
   assign tgt_ext = IW'(req_target_heading);

   // Wrapped error; exactly half a turn counts as positive
   assign half_turn = {1'b1, {(A - 1){1'b0}}};
   assign wrap_diff = tgt_ff - cur_ff;
   assign wrap_neg  = wrap_diff > half_turn;

   // Clamp the desired rate magnitude, the maximum wins over the minimum
   always_comb begin
      want_w  = WW'(gprod_ff[DW-1:8]);
      min_eff = (cfg.min_turn_rate < cfg.max_turn_rate) ? cfg.min_turn_rate
                                                        : cfg.max_turn_rate;
      if (want_w < WW'(min_eff)) begin
         want_c = min_eff;
      end else if (want_w > WW'(cfg.max_turn_rate)) begin
         want_c = cfg.max_turn_rate;
      end else begin
         want_c = want_w[19:0];
      end
      want_s    = {1'b0, want_c};
      desired_w = err_neg_ff ? 21'(21'd0 - want_s) : want_s;
      diff_w    = {desired_w[20], desired_w} - {rate_ff[20], rate_ff};
   end

   // Blend step, rounded to nearest
   assign blend_prod = 46'(mag_diff_ff) * 46'(alpha_cap_ff);
   assign blend_rnd  = blend_prod + 46'(24'h800000);

   // Eased rate, saturated to the rate limit; a zero slew speed takes the desired rate
   always_comb begin
      rate_sum = {rate_ff[20], rate_ff[20], rate_ff} +
                 (diff_neg_ff ? 23'(23'd0 - {1'b0, step_ff}) : {1'b0, step_ff});
      if (cfg.slew_speed == 16'd0) begin
         rate_sat = desired_ff;
      end else if ($signed(rate_sum) > $signed({2'b00, RATE_LIMIT})) begin
         rate_sat = RATE_LIMIT;
      end else if ($signed(rate_sum) < -$signed({2'b00, RATE_LIMIT})) begin
         rate_sat = 21'(21'd0 - RATE_LIMIT);
      end else begin
         rate_sat = rate_sum[20:0];
      end
   end

   assign rate_abs = rate_new_ff[20] ? 21'(21'd0 - rate_new_ff) : rate_new_ff;

   // Heading advance: travel over 65536, rounded away from zero on ties
   assign adv_rnd  = {1'b0, mag_d_ff} + 37'd32768;
   assign adv      = adv_rnd[36:16];
   assign head_sum = rate_new_ff[20] ? HW'(HW'(cur_ff) - HW'(adv))
                                     : HW'(HW'(cur_ff) + HW'(adv));

   // Snap rate from the divider, saturated
   assign q_sat    = (quo > DW'(RATE_LIMIT)) ? RATE_LIMIT : quo[20:0];
   assign q_signed = err_neg_ff ? 21'(21'd0 - q_sat) : q_sat;

   rlhc_divider #(
      .DIVIDEND_BITS (DW)
   ) u_rlhc_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.op == OP_DIV),
      .dividend ({mag_e_ff, 16'h0000}),
      .divisor  (dt_ff),
      .busy     (status.div_busy),
      .quotient (quo)
   );

   // Status for the controller
   assign status.dt_zero = dt_ff == 16'd0;
   assign status.in_tol  = mag_e_ff[A-1:1] == '0;
   assign status.snap    = (rate_new_ff != 21'd0) && (rate_new_ff[20] == err_neg_ff) &&
                           (CW'(mag_d_ff) >= CW'({mag_e_ff, 16'h0000}));

   // Select the result heading
   always_comb begin
      case (cmd.op)
         OP_OUT_TOL, OP_OUT_SNAP: head_sel = tgt_ff;
         OP_OUT_MOVE:             head_sel = head_sum[A-1:0];
         default:                 head_sel = cur_ff;
      endcase
      head_ext = IW'(head_sel);
   end

   // Update the kept turn rate when a result is written
   always_comb begin
      case (cmd.op)
         OP_OUT_TOL:  rate_in = 21'd0;
         OP_OUT_SNAP: rate_in = q_signed;
         OP_OUT_MOVE: rate_in = rate_new_ff;
         default:     rate_in = rate_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= 21'd0;
      end else begin
         rate_ff <= rate_in;
      end
   end

   // Advance the datapath one operation
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            cur_ff <= cur_ext[A-1:0];
            tgt_ff <= tgt_ext[A-1:0];
            dt_ff  <= req_tick_time;
         end
         OP_ERR: begin
            err_neg_ff <= wrap_neg;
            mag_e_ff   <= wrap_neg ? A'(A'(0) - wrap_diff) : wrap_diff;
         end
         OP_GAIN: begin
            gprod_ff <= DW'(mag_e_ff) * DW'(cfg.error_gain);
            alpha_ff <= 32'(dt_ff) * 32'(cfg.slew_speed);
         end
         OP_DIFF: begin
            desired_ff   <= desired_w;
            diff_neg_ff  <= diff_w[21];
            mag_diff_ff  <= diff_w[21] ? 21'(22'd0 - diff_w) : diff_w[20:0];
            alpha_cap_ff <= (alpha_ff > ALPHA_ONE) ? ALPHA_ONE[24:0] : alpha_ff[24:0];
         end
         OP_BLEND: begin
            step_ff <= blend_rnd[45:24];
         end
         OP_RATE: begin
            rate_new_ff <= rate_sat;
         end
         OP_TRAVEL: begin
            mag_d_ff <= 36'(rate_abs[19:0]) * 36'(dt_ff);
         end
         OP_OUT_HOLD, OP_OUT_TOL, OP_OUT_SNAP, OP_OUT_MOVE: begin
            heading_ff <= head_ext[15:0];
            turn_ff    <= rate_in;
            arrived_ff <= cmd.op != OP_OUT_HOLD && cmd.op != OP_OUT_MOVE;
         end
         default: begin
         end
      endcase
   end

   assign rsp_new_heading = heading_ff;
   assign rsp_turn_rate   = $signed(turn_ff);
   assign rsp_arrived     = arrived_ff;

endmodule

>>> rtl/rlhc_ctrl.sv
// ----------------------------------------------------------------------------
// rlhc_ctrl
// Controller: sequences one transaction through the datapath and owns the
// input stall and the result valid.
// ----------------------------------------------------------------------------
module rlhc_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  rlhc_pkg::rlhc_status_type status,
   output rlhc_pkg::rlhc_cmd_type    cmd
);
   import rlhc_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ERR,
      ST_GAIN,
      ST_DIFF,
      ST_BLEND,
      ST_RATE,
      ST_TRAVEL,
      ST_CMP,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type   state_ff;
   state_type   state_in;
   rlhc_op_type out_sel_ff;
   rlhc_op_type out_sel_in;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic        load_out;

   // Next state and datapath command
   always_comb begin
      state_in   = state_ff;
      out_sel_in = out_sel_ff;
      cmd.op     = OP_NONE;
      load_out   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = ST_ERR;
            end
         end
         ST_ERR: begin
            cmd.op   = OP_ERR;
            state_in = ST_GAIN;
         end
         ST_GAIN: begin
            cmd.op = OP_GAIN;
            if (status.dt_zero) begin
               out_sel_in = OP_OUT_HOLD;
               state_in   = ST_DONE;
            end else if (status.in_tol) begin
               out_sel_in = OP_OUT_TOL;
               state_in   = ST_DONE;
            end else begin
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            cmd.op   = OP_DIFF;
            state_in = ST_BLEND;
         end
         ST_BLEND: begin
            cmd.op   = OP_BLEND;
            state_in = ST_RATE;
         end
         ST_RATE: begin
            cmd.op   = OP_RATE;
            state_in = ST_TRAVEL;
         end
         ST_TRAVEL: begin
            cmd.op   = OP_TRAVEL;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (status.snap) begin
               cmd.op   = OP_DIV;
               state_in = ST_DIV;
            end else begin
               out_sel_in = OP_OUT_MOVE;
               state_in   = ST_DONE;
            end
         end
         ST_DIV: begin
            if (!status.div_busy) begin
               out_sel_in = OP_OUT_SNAP;
               state_in   = ST_DONE;
            end
         end
         ST_DONE: begin
            // Write the result once the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.op   = out_sel_ff;
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = load_out || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_sel_ff   <= OP_OUT_HOLD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_sel_ff   <= out_sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> rtl/rate_limited_heading_controller_top.sv
// ----------------------------------------------------------------------------
// rate_limited_heading_controller_top
// Rate limited proportional heading controller.
//
// Usage:
//   The req channel carries one control tick: current heading, target heading
//   and elapsed time. The rsp channel returns the new heading, the updated
//   signed turn rate and an arrived flag. Both channels use valid/stall; a
//   transaction moves at a clock edge with valid high and stall low.
//   Registers are to be written on the csr port only while no transaction is
//   in flight; the block itself does not enforce this. One transaction is
//   worked on at a time. After acceptance, a zero time step or an error
//   within one unit goes straight to the result; a normal move passes the
//   registered gain, blend and travel multiplies; and when the step reaches
//   the target, the bit-serial divider forms the snap rate, one quotient bit
//   per cycle, before the result is written.
//   req_stall rises the cycle after acceptance and drops when the result is
//   written to the output register, so a new transaction is taken while the
//   previous result still waits. If the receiver stalls and the output
//   register is full, the finished result waits inside the block.
//   Synchronous reset clears the turn rate to zero, loads the register reset
//   values and drops rsp_valid.
// ----------------------------------------------------------------------------
module rate_limited_heading_controller_top #(
   parameter int unsigned ANGLE_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [15:0]                          req_current_heading,
   input  logic [15:0]                          req_target_heading,
   input  logic [15:0]                          req_tick_time,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [15:0]                          rsp_new_heading,
   output logic signed [20:0]                   rsp_turn_rate,
   output logic                                 rsp_arrived,
   input  logic                                 csr_write,
   input  logic [rlhc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [rlhc_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import rlhc_pkg::*;

   rlhc_cfg_type    cfg;
   rlhc_cmd_type    cmd;
   rlhc_status_type status;

   rlhc_csr u_rlhc_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rlhc_ctrl u_rlhc_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rlhc_datapath #(
      .ANGLE_BITS (ANGLE_BITS)
   ) u_rlhc_datapath (
      .clock               (clock),
      .reset               (reset),
      .cfg                 (cfg),
      .cmd                 (cmd),
      .status              (status),
      .req_current_heading (req_current_heading),
      .req_target_heading  (req_target_heading),
      .req_tick_time       (req_tick_time),
      .rsp_new_heading     (rsp_new_heading),
      .rsp_turn_rate       (rsp_turn_rate),
      .rsp_arrived         (rsp_arrived)
   );

endmodule

>>> rtl/rlhc_checker.sv
// ----------------------------------------------------------------------------
// rlhc_checker
// Port-level checks of the heading controller, bound to the top level.
// ----------------------------------------------------------------------------
module rlhc_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [15:0]        rsp_new_heading,
   input logic signed [20:0] rsp_turn_rate,
   input logic               rsp_arrived
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_new_heading) &&
                                 $stable(rsp_turn_rate) && $stable(rsp_arrived))
      else $error("stalled result changed");

   // One transaction at a time: the input stalls after acceptance for the length of the shortest transaction
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall ##1 req_stall ##1 req_stall)
      else $error("input taken while a transaction is in flight");

   // Reset drops the result and opens the input
   a_reset_state: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("reset did not clear the handshake state");

   // The turn rate stays inside its symmetric limit
   a_rate_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_turn_rate[20] && rsp_turn_rate[19:0] == 20'd0))
      else $error("turn rate outside its limit");

endmodule

bind rate_limited_heading_controller_top rlhc_checker u_rlhc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_new_heading (rsp_new_heading),
   .rsp_turn_rate   (rsp_turn_rate),
   .rsp_arrived     (rsp_arrived)
);
